// ===== design/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int unsigned NUM_W      = 32;
	localparam int unsigned CHAR_W     = 7;
	localparam int unsigned DEC_DIGITS = 10;
	localparam int unsigned HEX_DIGITS = 8;
	localparam int unsigned MAX_CHARS  = 11;
	localparam int unsigned CNT_W      = 4;
	localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
	localparam int unsigned NUM_STAGES = 4;
	localparam int unsigned STEPS      = NUM_W / NUM_STAGES;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

	typedef struct packed {
		logic [NUM_W-1:0] bin;
		logic [NUM_W-1:0] raw;
		logic [BCD_W-1:0] bcd;
		logic             neg;
		logic             hex;
	} work_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		if (d < 4'd10)
			return CH_ZERO + CHAR_W'(d);
		else
			return CH_A + CHAR_W'(d - 4'd10);
	endfunction

	function automatic work_t dabble_step(input work_t w);
		work_t r;
		r = w;
		for (int d = 0; d < DEC_DIGITS; d++) begin
			if (r.bcd[d*4 +: 4] >= 4'd5)
				r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
		end
		r.bcd = {r.bcd[BCD_W-2:0], r.bin[NUM_W-1]};
		r.bin = {r.bin[NUM_W-2:0], 1'b0};
		return r;
	endfunction

endpackage

// ===== design/i2a_if.sv =====
// ----------------------------------------------------------------------------
// i2a interfaces
// Input and output beat channels of the formatter.
// ----------------------------------------------------------------------------
interface i2a_in_if import i2a_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] number;
	logic             signed_mode;
	logic             hex_base;
	modport source (output valid, number, signed_mode, hex_base, input ready);
	modport sink   (input valid, number, signed_mode, hex_base, output ready);
endinterface

interface i2a_out_if import i2a_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last_char;
	modport source (output valid, character, last_char, input ready);
	modport sink   (input valid, character, last_char, output ready);
endinterface

// ===== design/i2a_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// i2a_dabble_stage
// One pipeline stage of shift-and-add-3 binary to BCD conversion.
// ----------------------------------------------------------------------------
module i2a_dabble_stage import i2a_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  work_t up_data,
	output logic  dn_valid,
	input  logic  dn_ready,
	output work_t dn_data
);

	logic  v_s;
	work_t d_s;
	work_t nxt;

	always_comb begin
		nxt = up_data;
		for (int i = 0; i < STEPS; i++)
			nxt = dabble_step(nxt);
	end

	assign up_ready = !v_s || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= 1'b0;
		end else if (up_ready) begin
			v_s <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid)
			d_s <= nxt;
	end

	assign dn_valid = v_s;
	assign dn_data  = d_s;

endmodule

// ===== design/i2a_serialiser.sv =====
// ----------------------------------------------------------------------------
// i2a_serialiser
// Builds one item's character run and sends one beat per cycle while ready.
// ----------------------------------------------------------------------------
module i2a_serialiser import i2a_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  work_t up_data,
	i2a_out_if.source text
);

	logic [CHAR_W-1:0] ch_q [MAX_CHARS];
	logic [CNT_W-1:0]  cnt_q;
	logic [3:0]        dg [DEC_DIGITS];
	logic [CHAR_W-1:0] ld_ch [MAX_CHARS];
	logic [CNT_W-1:0]  nd;
	logic [CNT_W-1:0]  ld_cnt;
	logic              load;
	logic              beat;

	always_comb begin
		int k;
		for (int j = 0; j < DEC_DIGITS; j++) begin
			if (up_data.hex)
				dg[j] = (j < HEX_DIGITS) ? up_data.raw[(j % HEX_DIGITS)*4 +: 4] : 4'd0;
			else
				dg[j] = up_data.bcd[j*4 +: 4];
		end
		nd = CNT_W'(1);
		for (int j = 0; j < DEC_DIGITS; j++) begin
			if (dg[j] != 4'd0)
				nd = CNT_W'(j + 1);
		end
		for (int j = 0; j < MAX_CHARS; j++) begin
			k = int'(nd) - 1 - (j - (up_data.neg ? 1 : 0));
			if (up_data.neg && j == 0)
				ld_ch[j] = CH_MINUS;
			else if (k >= 0 && k < DEC_DIGITS)
				ld_ch[j] = digit_char(dg[k]);
			else
				ld_ch[j] = CH_ZERO;
		end
		ld_cnt = nd + CNT_W'(up_data.neg);
	end

	assign beat     = text.valid && text.ready;
	assign up_ready = (cnt_q == '0) || (cnt_q == CNT_W'(1) && text.ready);
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= ld_cnt;
		end else if (beat) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch_q <= ld_ch;
		end else if (beat) begin
			for (int j = 0; j < MAX_CHARS - 1; j++)
				ch_q[j] <= ch_q[j+1];
		end
	end

	assign text.valid     = cnt_q != '0;
	assign text.character = ch_q[0];
	assign text.last_char = cnt_q == CNT_W'(1);

endmodule

// ===== design/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 32-bit value as ASCII decimal or lowercase hex, one char a beat.
// An input beat passes the input register, dabble stages and serialiser.
// Throughput: one character per cycle while text.ready is high; an item has
// 1 to 11 characters, sent by the single-character output serialiser.
// Reset clears all valid bits and the character count; data is unreset.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter import i2a_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	i2a_in_if.sink    item,
	i2a_out_if.source text
);

	logic  v_s1;
	work_t d_s1;
	work_t mag;
	logic  vld [NUM_STAGES+1];
	logic  rdy [NUM_STAGES+1];
	work_t dat [NUM_STAGES+1];

	always_comb begin
		mag.neg = item.signed_mode && !item.hex_base && item.number[NUM_W-1];
		mag.hex = item.hex_base;
		mag.raw = mag.neg ? (~item.number + NUM_W'(1)) : item.number;
		mag.bin = mag.raw;
		mag.bcd = '0;
	end

	assign item.ready = !v_s1 || rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid)
			d_s1 <= mag;
	end

	assign vld[0] = v_s1;
	assign dat[0] = d_s1;

	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
		i2a_dabble_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[g]),
			.up_ready (rdy[g]),
			.up_data  (dat[g]),
			.dn_valid (vld[g+1]),
			.dn_ready (rdy[g+1]),
			.dn_data  (dat[g+1])
		);
	end

	i2a_serialiser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld[NUM_STAGES]),
		.up_ready (rdy[NUM_STAGES]),
		.up_data  (dat[NUM_STAGES]),
		.text     (text)
	);

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.character == CH_MINUS |-> !text.last_char)
		else $error("minus sign marked as last character");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.ready && text.last_char
		&& !(vld[NUM_STAGES] && rdy[NUM_STAGES]) |=> !text.valid)
		else $error("characters after end of run");

	a_no_load_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && !text.last_char |-> !rdy[NUM_STAGES])
		else $error("serialiser ready in mid run");

endmodule
